// ===== hw/rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, modulus constants and unit handshake types for the
// modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int BASE_W  = 30;
    localparam int EXP_W   = 32;
    localparam int POWER_W = 30;

    localparam int PROD_W  = 2 * BASE_W;
    localparam int QUOT_W  = 31;
    localparam int REM_W   = 32;

    localparam logic [BASE_W-1:0] PRIME = 30'd1000000007;
    localparam logic [QUOT_W-1:0] MU    = 31'd1152921496;

    localparam logic [REM_W-1:0]  PRIME_X1 = 32'd1000000007;
    localparam logic [REM_W-1:0]  PRIME_X2 = 32'd2000000014;

    typedef logic [BASE_W-1:0] residue_t;

    typedef struct packed {
        logic valid;
        logic sqr;
    } mexp_op_t;

endpackage

// ===== hw/rtl/mexp_modmul.sv =====
// ----------------------------------------------------------------------------
// mexp_modmul
// Four-stage pipelined multiplier modulo the prime, Barrett reduction.
// ----------------------------------------------------------------------------
module mexp_modmul (
    input  logic                aclk,
    input  logic                aresetn,
    input  mexp_pkg::mexp_op_t  req,
    input  mexp_pkg::residue_t  op_a,
    input  mexp_pkg::residue_t  op_b,
    output mexp_pkg::mexp_op_t  rsp,
    output mexp_pkg::residue_t  result
);
    import mexp_pkg::*;

    mexp_op_t            s1_op_reg, s2_op_reg, s3_op_reg, s4_op_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [REM_W-1:0]    prod_lo_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic [REM_W-1:0]    rem_reg;
    residue_t            result_reg;

    logic [PROD_W-1:0]          prod_next;
    logic [2*QUOT_W-1:0]        est_full;
    logic [QUOT_W-1:0]          quot_next;
    logic [QUOT_W+BASE_W-1:0]   qp_full;
    logic [REM_W-1:0]           rem_next;
    residue_t                   result_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);
    assign est_full  = (2*QUOT_W)'(prod_reg[PROD_W-1:BASE_W-1]) * (2*QUOT_W)'(MU);
    assign quot_next = est_full[2*QUOT_W-1:QUOT_W];
    assign qp_full   = (QUOT_W+BASE_W)'(quot_reg) * (QUOT_W+BASE_W)'(PRIME);
    assign rem_next  = prod_lo_reg - qp_full[REM_W-1:0];

    always_comb begin
        if (rem_reg >= PRIME_X2) begin
            result_next = BASE_W'(rem_reg - PRIME_X2);
        end else if (rem_reg >= PRIME_X1) begin
            result_next = BASE_W'(rem_reg - PRIME_X1);
        end else begin
            result_next = rem_reg[BASE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_op_reg <= '0;
            s2_op_reg <= '0;
            s3_op_reg <= '0;
            s4_op_reg <= '0;
        end else begin
            s1_op_reg <= req;
            s2_op_reg <= s1_op_reg;
            s3_op_reg <= s2_op_reg;
            s4_op_reg <= s3_op_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg    <= prod_next;
        prod_lo_reg <= prod_reg[REM_W-1:0];
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        result_reg  <= result_next;
    end

    assign rsp    = s4_op_reg;
    assign result = result_reg;

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ^ exponent mod 1000000007 by right-to-left square-and-multiply on
// one shared pipelined modular multiplier.
//
//   channel   direction  ports                          payload
//   request   in         s_valid s_ready                s_base[29:0] s_exponent[31:0]
//   result    out        m_valid m_ready                m_power[29:0]
//
// Each exponent bit up to the highest set one is handled in turn: a multiply and
// a square enter the 4-stage multiplier back to back and the square result
// must return before the next bit. A zero exponent gives 1 in the cycle
// after it is accepted.
// One request at a time; s_ready is low until the result is taken.
// Synchronous active-low reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int EXP_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mexp_pkg::BASE_W-1:0]   s_base,
    input  logic [mexp_pkg::EXP_W-1:0]    s_exponent,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mexp_pkg::POWER_W-1:0]  m_power
);
    import mexp_pkg::*;

    localparam int EXP_USED = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
    localparam logic [EXP_W-1:0] EXP_MASK = {EXP_W{1'b1}} >> (EXP_W - EXP_USED);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SQR  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]        state_reg, state_next;
    residue_t          base_reg, base_next;
    residue_t          acc_reg, acc_next;
    logic [EXP_W-1:0]  exp_reg, exp_next;

    logic [EXP_W-1:0]  exp_in;
    residue_t          base_in;
    mexp_op_t          req, rsp;
    residue_t          op_a, result;

    assign exp_in  = s_exponent & EXP_MASK;
    assign base_in = (s_base >= PRIME) ? BASE_W'(s_base - PRIME) : s_base;

    always_comb begin
        req.valid = (state_reg == ST_MUL) || (state_reg == ST_SQR);
        req.sqr   = (state_reg == ST_SQR);
        op_a      = req.sqr ? base_reg : acc_reg;
    end

    always_comb begin
        state_next = state_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        exp_next   = exp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    base_next  = base_in;
                    acc_next   = BASE_W'(1);
                    exp_next   = exp_in;
                    state_next = (exp_in == '0) ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_SQR;
            end
            ST_SQR: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (rsp.valid && !rsp.sqr && exp_reg[0]) begin
                    acc_next = result;
                end
                if (rsp.valid && rsp.sqr) begin
                    base_next  = result;
                    exp_next   = exp_reg >> 1;
                    state_next = ((exp_reg >> 1) == '0) ? ST_DONE : ST_MUL;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        acc_reg  <= acc_next;
        exp_reg  <= exp_next;
    end

    mexp_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .op_a    (op_a),
        .op_b    (base_reg),
        .rsp     (rsp),
        .result  (result)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_DONE);
    assign m_power = acc_reg;

    a_rsp_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.valid |-> (state_reg == ST_WAIT))
        else $error("multiplier response outside wait state");

    a_power_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_power < PRIME))
        else $error("result not reduced below modulus");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("accepting while a result is pending");

    a_zero_exp: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && ((s_exponent & EXP_MASK) == '0))
            |=> (m_valid && (m_power == POWER_W'(1))))
        else $error("zero exponent did not give one");

endmodule
